// File: hw/rtl/mlfe_pkg.sv
// ----------------------------------------------------------------------------
// mlfe_pkg
// Shared constants, job type and CRC/BCD helpers for the meter link engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfe_pkg;

	localparam int REPLY_MAX_DEF = 128;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0]  CMD_ENERGY = 8'h27;
	localparam logic [7:0]  CMD_POWER  = 8'h63;
	localparam logic [19:0] ID_LIMIT   = 20'd999999;

	// Reply byte positions and length limits
	localparam int DATA_FIRST  = 5;
	localparam int DATA_LAST   = 20;
	localparam int DATA_BYTES  = 16;
	localparam int CRC_START   = 2;
	localparam int SHORT_MAX   = 8;
	localparam int ENERGY_MIN  = 23;
	localparam int POWER_MIN   = 11;
	localparam int POWER_BYTES = 4;

	localparam int Q_DEPTH = 2;

	// Result kinds
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_STATUS  = 2'd1;
	localparam logic [1:0] KIND_READING = 2'd2;

	// Status codes
	localparam logic [2:0] ST_DECODED   = 3'd0;
	localparam logic [2:0] ST_UNDECODED = 3'd1;
	localparam logic [2:0] ST_CRC_ERR   = 3'd2;
	localparam logic [2:0] ST_SHORT     = 3'd3;
	localparam logic [2:0] ST_BAD_DATA  = 3'd4;
	localparam logic [2:0] ST_BAD_ID    = 3'd5;

	// Last result step of each job, and last request step folded into the CRC
	localparam logic [2:0] REQ_LAST_STEP    = 3'd6;
	localparam logic [2:0] REQ_CRC_STEP     = 3'd4;
	localparam logic [2:0] ENERGY_LAST_STEP = 3'd4;
	localparam logic [2:0] POWER_LAST_STEP  = 3'd2;

	typedef enum logic [1:0] {
		JOB_REQUEST = 2'd0,
		JOB_STATUS  = 2'd1,
		JOB_ENERGY  = 2'd2,
		JOB_POWER   = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t                   jkind;
		logic [2:0]                  status;
		logic [19:0]                 id;
		logic [7:0]                  cmd;
		logic [DATA_BYTES-1:0][7:0]  data;
	} job_t;

	// One byte of CRC-16, reflected polynomial, bit at a time
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic bad_digit(input logic [7:0] b);
		return (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
	endfunction

	// Two BCD digits to binary, 0..99
	function automatic logic [6:0] pair_value(input logic [7:0] b);
		return 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mlfe_front.sv
// ----------------------------------------------------------------------------
// mlfe_front
// Accepts items, runs the reply receiver and classifies each closing item
// into a job for the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfe_front #(
	parameter int REPLY_MAX = mlfe_pkg::REPLY_MAX_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire logic          operation,
	input  wire logic [19:0]   device_id,
	input  wire logic [7:0]    command,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          rx_last,
	input  wire logic          q_full,
	output logic               push,
	output mlfe_pkg::job_t     push_job
);

	localparam int CNT_W = $clog2(REPLY_MAX + 1);

	logic [15:0]      crc_q;
	logic [7:0]       dly0_q;
	logic [7:0]       dly1_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       pend_cmd_q;
	logic [7:0]       data_q [mlfe_pkg::DATA_BYTES];
	logic             bad_q  [mlfe_pkg::DATA_BYTES];

	logic                              accept;
	logic                              take;
	logic                              wr;
	logic [CNT_W-1:0]                  wsub;
	logic [3:0]                        widx;
	logic [15:0]                       crc_n;
	logic [7:0]                        dly0_n;
	logic [7:0]                        dly1_n;
	logic [CNT_W-1:0]                  cnt_n;
	logic [mlfe_pkg::DATA_BYTES-1:0]   bad_n;
	logic [mlfe_pkg::DATA_BYTES-1:0][7:0] data_n;
	logic                              id_ok;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;
	assign id_ok      = device_id <= mlfe_pkg::ID_LIMIT;

	// Receiver next state for a reply byte
	assign take   = operation && (cnt_q < CNT_W'(REPLY_MAX));
	assign crc_n  = (take && cnt_q >= CNT_W'(mlfe_pkg::CRC_START))
		? mlfe_pkg::crc_byte(crc_q, dly1_q) : crc_q;
	assign dly1_n = take ? dly0_q : dly1_q;
	assign dly0_n = take ? rx_byte : dly0_q;
	assign cnt_n  = take ? cnt_q + CNT_W'(1) : cnt_q;
	assign wr     = take && cnt_q >= CNT_W'(mlfe_pkg::DATA_FIRST)
		&& cnt_q <= CNT_W'(mlfe_pkg::DATA_LAST);
	assign wsub   = cnt_q - CNT_W'(mlfe_pkg::DATA_FIRST);
	assign widx   = wsub[3:0];

	// Merge the byte of this cycle so the closing byte is seen too
	always_comb begin
		for (int i = 0; i < mlfe_pkg::DATA_BYTES; i++) begin
			if (wr && widx == 4'(i)) begin
				data_n[i] = rx_byte;
				bad_n[i]  = mlfe_pkg::bad_digit(rx_byte);
			end else begin
				data_n[i] = data_q[i];
				bad_n[i]  = bad_q[i];
			end
		end
	end

	always_comb begin
		push_job.id     = device_id;
		push_job.cmd    = command;
		push_job.data   = data_n;
		push_job.jkind  = mlfe_pkg::JOB_STATUS;
		push_job.status = mlfe_pkg::ST_DECODED;
		if (!operation) begin
			if (id_ok) begin
				push_job.jkind = mlfe_pkg::JOB_REQUEST;
			end else begin
				push_job.status = mlfe_pkg::ST_BAD_ID;
			end
		end else if (cnt_n <= CNT_W'(mlfe_pkg::SHORT_MAX)) begin
			push_job.status = mlfe_pkg::ST_SHORT;
		end else if (crc_n != {dly0_n, dly1_n}) begin
			push_job.status = mlfe_pkg::ST_CRC_ERR;
		end else if (pend_cmd_q == mlfe_pkg::CMD_ENERGY) begin
			if (cnt_n < CNT_W'(mlfe_pkg::ENERGY_MIN) || |bad_n) begin
				push_job.status = mlfe_pkg::ST_BAD_DATA;
			end else begin
				push_job.jkind = mlfe_pkg::JOB_ENERGY;
			end
		end else if (pend_cmd_q == mlfe_pkg::CMD_POWER) begin
			if (cnt_n < CNT_W'(mlfe_pkg::POWER_MIN)
					|| |bad_n[mlfe_pkg::POWER_BYTES-1:0]) begin
				push_job.status = mlfe_pkg::ST_BAD_DATA;
			end else begin
				push_job.jkind = mlfe_pkg::JOB_POWER;
			end
		end else begin
			push_job.status = mlfe_pkg::ST_UNDECODED;
		end
	end

	assign push = accept && (!operation || rx_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= mlfe_pkg::CRC_INIT;
			dly0_q     <= '0;
			dly1_q     <= '0;
			cnt_q      <= '0;
			pend_cmd_q <= '0;
		end else if (accept) begin
			if (!operation) begin
				if (id_ok) begin
					pend_cmd_q <= command;
					crc_q      <= mlfe_pkg::CRC_INIT;
					dly0_q     <= '0;
					dly1_q     <= '0;
					cnt_q      <= '0;
				end
			end else if (rx_last) begin
				crc_q  <= mlfe_pkg::CRC_INIT;
				dly0_q <= '0;
				dly1_q <= '0;
				cnt_q  <= '0;
			end else begin
				crc_q  <= crc_n;
				dly0_q <= dly0_n;
				dly1_q <= dly1_n;
				cnt_q  <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr) begin
			data_q[widx] <= rx_byte;
			bad_q[widx]  <= mlfe_pkg::bad_digit(rx_byte);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mlfe_queue.sv
// ----------------------------------------------------------------------------
// mlfe_queue
// Short job queue between the front and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfe_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  mlfe_pkg::job_t       push_job,
	output logic                 full,
	input  wire logic            pop,
	output mlfe_pkg::job_t       head_job,
	output logic                 empty
);

	localparam int PTR_W = (mlfe_pkg::Q_DEPTH > 1) ? $clog2(mlfe_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(mlfe_pkg::Q_DEPTH + 1);

	mlfe_pkg::job_t   slot_q [mlfe_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(mlfe_pkg::Q_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(mlfe_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mlfe_back.sv
// ----------------------------------------------------------------------------
// mlfe_back
// Result sequencer: steps through one job at a time into the output register,
// one result per cycle while that register is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mlfe_pkg::job_t     head_job,
	input  wire logic          q_empty,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [1:0]         kind,
	output logic [7:0]         tx_byte,
	output logic [2:0]         status,
	output logic [26:0]        reading,
	output logic [1:0]         reading_index,
	output logic               reading_scale,
	output logic               last
);

	mlfe_pkg::job_t act_q;
	logic           act_valid_q;
	logic [2:0]     step_q;
	logic [15:0]    crc_q;

	logic           out_load;
	logic           adv;
	logic           fin;
	logic [2:0]     last_step;
	logic [7:0]     tx_sel;
	logic [6:0]     p0, p1, p2, p3;
	logic [26:0]    energy_val;
	logic [26:0]    power_val;

	logic [1:0]     r_kind;
	logic [7:0]     r_tx;
	logic [2:0]     r_status;
	logic [26:0]    r_reading;
	logic [1:0]     r_idx;
	logic           r_scale;
	logic           r_last;

	assign p0 = mlfe_pkg::pair_value(act_q.data[0]);
	assign p1 = mlfe_pkg::pair_value(act_q.data[1]);
	assign p2 = mlfe_pkg::pair_value(act_q.data[2]);
	assign p3 = mlfe_pkg::pair_value(act_q.data[3]);

	assign energy_val = 27'(p0) * 27'd1000000 + 27'(p1) * 27'd10000
		+ 27'(p2) * 27'd100 + 27'(p3);
	assign power_val  = 27'(p0) * 27'd100 + 27'(p1);

	always_comb begin
		case (step_q)
			3'd1:    tx_sel = {4'h0, act_q.id[19:16]};
			3'd2:    tx_sel = act_q.id[15:8];
			3'd3:    tx_sel = act_q.id[7:0];
			3'd4:    tx_sel = act_q.cmd;
			3'd5:    tx_sel = crc_q[7:0];
			3'd6:    tx_sel = crc_q[15:8];
			default: tx_sel = 8'h00;
		endcase
	end

	always_comb begin
		r_kind    = mlfe_pkg::KIND_STATUS;
		r_tx      = '0;
		r_status  = mlfe_pkg::ST_DECODED;
		r_reading = '0;
		r_idx     = '0;
		r_scale   = 1'b0;
		r_last    = 1'b0;
		last_step = '0;
		unique case (act_q.jkind)
			mlfe_pkg::JOB_REQUEST: begin
				last_step = mlfe_pkg::REQ_LAST_STEP;
				r_kind    = mlfe_pkg::KIND_TX;
				r_tx      = tx_sel;
				r_last    = step_q == mlfe_pkg::REQ_LAST_STEP;
			end
			mlfe_pkg::JOB_STATUS: begin
				r_status = act_q.status;
				r_last   = 1'b1;
			end
			mlfe_pkg::JOB_ENERGY: begin
				last_step = mlfe_pkg::ENERGY_LAST_STEP;
				if (step_q == mlfe_pkg::ENERGY_LAST_STEP) begin
					r_last = 1'b1;
				end else begin
					r_kind    = mlfe_pkg::KIND_READING;
					r_reading = energy_val;
					r_idx     = step_q[1:0];
				end
			end
			mlfe_pkg::JOB_POWER: begin
				last_step = mlfe_pkg::POWER_LAST_STEP;
				if (step_q == mlfe_pkg::POWER_LAST_STEP) begin
					r_last = 1'b1;
				end else begin
					r_kind    = mlfe_pkg::KIND_READING;
					r_reading = power_val;
					r_idx     = step_q[1:0];
					r_scale   = step_q == '0;
				end
			end
		endcase
	end

	assign out_load = !result_valid || !result_stall;
	assign adv      = act_valid_q && out_load;
	assign fin      = adv && step_q == last_step;
	assign pop      = !q_empty && (!act_valid_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= '0;
			act_valid_q  <= 1'b0;
			step_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				act_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (fin) begin
				act_valid_q <= 1'b0;
			end else if (adv) begin
				step_q <= step_q + 3'd1;
			end
			if (pop) begin
				act_q <= head_job;
			end else if (adv) begin
				// Advance the BCD window to the next reading
				if (act_q.jkind == mlfe_pkg::JOB_ENERGY) begin
					act_q.data <= act_q.data >> 32;
				end else if (act_q.jkind == mlfe_pkg::JOB_POWER) begin
					act_q.data <= act_q.data >> 16;
				end
			end
			if (out_load) begin
				result_valid <= act_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && act_q.jkind == mlfe_pkg::JOB_REQUEST
				&& step_q <= mlfe_pkg::REQ_CRC_STEP) begin
			crc_q <= mlfe_pkg::crc_byte((step_q == '0) ? mlfe_pkg::CRC_INIT : crc_q,
				tx_sel);
		end
		if (adv) begin
			kind          <= r_kind;
			tx_byte       <= r_tx;
			status        <= r_status;
			reading       <= r_reading;
			reading_index <= r_idx;
			reading_scale <= r_scale;
			last          <= r_last;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/meter_link_frame_engine.sv
// ----------------------------------------------------------------------------
// meter_link_frame_engine
// Request framing and reply checking for a serial energy-meter link.
// ----------------------------------------------------------------------------
// A request item (operation 0) yields the 7-byte request frame, CRC-16/Modbus
// appended low byte first, or one bad-id status when device_id is above
// 999999. Reply bytes (operation 1) are folded into a running CRC one byte per
// cycle while the job queue has room; the byte flagged rx_last closes the
// reply and yields either a single status, or the BCD readings followed by a
// decoded status (four readings for command 0x27, two for 0x63). Every
// transaction on the item side is accepted while the two-entry job queue has
// room, so reply bytes stream at one per cycle. The result sequencer emits one
// result per cycle while the output register is not stalled; an item yields 7
// results for a request, 5 for a decoded 0x27 reply, 3 for a decoded 0x63
// reply and 1 for any status, so the sustained rate of items producing
// results is set by the sequencer. When nothing is queued ahead of it, an
// item passes through the job queue and the sequencer's active-job register
// before its first result reaches the output register. Output fields that do
// not apply to a result's kind read as zero. There is no clearing pass after
// reset; the block accepts items from the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_link_frame_engine #(
	parameter int REPLY_MAX = mlfe_pkg::REPLY_MAX_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire logic          operation,
	input  wire logic [19:0]   device_id,
	input  wire logic [7:0]    command,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          rx_last,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [1:0]         kind,
	output logic [7:0]         tx_byte,
	output logic [2:0]         status,
	output logic [26:0]        reading,
	output logic [1:0]         reading_index,
	output logic               reading_scale,
	output logic               last
);

	logic           push;
	mlfe_pkg::job_t push_job;
	logic           q_full;
	logic           q_empty;
	logic           pop;
	mlfe_pkg::job_t head_job;

	// Front: receiver state and classification of each closing transaction
	mlfe_front #(
		.REPLY_MAX (REPLY_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.device_id  (device_id),
		.command    (command),
		.rx_byte    (rx_byte),
		.rx_last    (rx_last),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	// Job queue: lets the front keep taking bytes while results drain
	mlfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	// Back: one result per cycle into the output register unless it is stalled
	mlfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_job      (head_job),
		.q_empty       (q_empty),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.tx_byte       (tx_byte),
		.status        (status),
		.reading       (reading),
		.reading_index (reading_index),
		.reading_scale (reading_scale),
		.last          (last)
	);

	// Queue cannot be full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n) !(q_full && q_empty))
		else $error("job queue full and empty together");

	// Stall only ever comes from a full queue
	assert property (@(posedge clk) disable iff (!arst_n) item_stall |-> q_full)
		else $error("item side stalled with queue room");

	// A reading is never the closing result of a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == mlfe_pkg::KIND_READING) |-> !last)
		else $error("reading flagged as last result");

	// A status always closes its transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == mlfe_pkg::KIND_STATUS) |-> last)
		else $error("status not flagged as last result");

endmodule

`default_nettype wire
